FILE: rtl/lz_rle_byte_decompressor_defines.svh
// Assertion macros used by the checker in lrd_checker.sv.
`ifndef LZ_RLE_BYTE_DECOMPRESSOR_DEFINES_SVH
`define LZ_RLE_BYTE_DECOMPRESSOR_DEFINES_SVH

// The condition holds, so the consequence holds in the same cycle.
`define LRD_ASSERT_NOW(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("same-cycle check failed");

// The condition holds, so the consequence holds in the next cycle.
`define LRD_ASSERT_NEXT(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/lrd_pkg.sv
package lrd_pkg;

  localparam int WINDOW_DEPTH_DEF = 512;
  localparam int LENGTH_BITS_DEF  = 24;
  localparam int QUEUE_DEPTH      = 2;
  localparam int DIST_W           = 9;
  localparam int RUN_W            = 16;

  // Result status codes.
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_WRONG  = 2'd1;
  localparam logic [1:0] STS_BADREF = 2'd2;
  localparam logic [1:0] STS_DONE   = 2'd3;

  // Header kinds.
  localparam logic [1:0] KIND_LIT   = 2'd0;
  localparam logic [1:0] KIND_COPY9 = 2'd1;
  localparam logic [1:0] KIND_COPY2 = 2'd2;

  // Request kinds.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_LITERAL  = 3'd1,
    PH_DIST     = 3'd2,
    PH_COUNT    = 3'd3,
    PH_SKIP     = 3'd4,
    PH_VALUE    = 3'd5,
    PH_COPY_RUN = 3'd6,
    PH_FILL_RUN = 3'd7
  } phase_t;

  // One classified operation passed from the parser to the executor.
  typedef struct packed {
    logic              emit;
    logic              copy;
    logic [7:0]        data;
    logic [DIST_W-1:0] copy_dist;
    logic              want;
    logic [1:0]        status;
  } op_t;

endpackage

FILE: rtl/lrd_front.sv
module lrd_front import lrd_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  logic                   req_type,
  input  logic [7:0]             in_byte,
  input  logic [LENGTH_BITS-1:0] out_len,
  output op_t                    op
);

  localparam int CW = (LENGTH_BITS > DIST_W) ? LENGTH_BITS : DIST_W;

  phase_t                  phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0]  produced_r, produced_nxt;
  logic [RUN_W-1:0]        run_left_r, run_left_nxt;
  logic [DIST_W-1:0]       dist_r, dist_nxt;
  logic [7:0]              fill_r, fill_nxt;
  logic [7:0]              hdr_r, hdr_nxt;
  logic                    stopped_r, stopped_nxt;

  logic                    finished;
  logic                    live;
  logic                    run_ph;
  logic                    act;
  logic                    emit;
  logic                    bad_ref;
  logic [DIST_W-1:0]       dist_calc;
  logic [RUN_W-1:0]        run_dec;
  logic [1:0]              in_kind;
  logic [4:0]              in_amt;
  logic [5:0]              hdr_left;

  // Shared decode of the current item.
  assign finished  = (produced_r >= out_len);
  assign live      = !stopped_r && !finished;
  assign run_ph    = (phase_r == PH_COPY_RUN) || (phase_r == PH_FILL_RUN);
  assign act       = in_fire && live && ((req_type == REQ_TICK) == run_ph);
  assign emit      = (phase_r == PH_LITERAL) || run_ph;
  assign run_dec   = run_left_r - RUN_W'(1);
  assign in_kind   = in_byte[7:6];
  assign in_amt    = in_byte[4:0];
  assign hdr_left  = 6'd32 - {1'b0, hdr_r[4:0]};
  assign dist_calc = (hdr_r[7:6] == KIND_COPY9) ? {hdr_r[5], in_byte} : {in_byte, 1'b0};
  assign bad_ref   = (dist_calc == '0) || (CW'(dist_calc) > CW'(produced_r));

  // Next parse phase.
  always_comb begin
    phase_nxt = phase_r;
    if (act) begin
      case (phase_r)
        PH_HEADER: begin
          case (in_kind)
            KIND_LIT:   phase_nxt = (in_amt == 5'd31) ? PH_HEADER : PH_LITERAL;
            KIND_COPY9: phase_nxt = PH_DIST;
            KIND_COPY2: phase_nxt = PH_DIST;
            default:    phase_nxt = in_byte[5] ? PH_HEADER : PH_COUNT;
          endcase
        end
        PH_DIST:  phase_nxt = bad_ref ? PH_DIST : PH_COPY_RUN;
        PH_COUNT: phase_nxt = PH_SKIP;
        PH_SKIP:  phase_nxt = PH_VALUE;
        PH_VALUE: phase_nxt = (run_left_r != '0) ? PH_FILL_RUN : PH_HEADER;
        default:  phase_nxt = (run_dec == '0) ? PH_HEADER : phase_r;
      endcase
    end
  end

  // Datapath updates and the classified operation.
  always_comb begin
    produced_nxt = produced_r;
    run_left_nxt = run_left_r;
    dist_nxt     = dist_r;
    fill_nxt     = fill_r;
    hdr_nxt      = hdr_r;
    stopped_nxt  = stopped_r;
    op           = '0;
    op.status    = STS_OK;
    if (stopped_r) begin
      op.status = STS_BADREF;
    end else if (finished) begin
      op.status = STS_DONE;
    end else if ((req_type == REQ_TICK) != run_ph) begin
      op.status = STS_WRONG;
    end else begin
      case (phase_r)
        PH_HEADER: begin
          hdr_nxt = in_byte;
          case (in_kind)
            KIND_LIT:   run_left_nxt = RUN_W'(5'd31 - in_amt);
            KIND_COPY9: run_left_nxt = RUN_W'(6'd35 - {1'b0, in_amt});
            KIND_COPY2: run_left_nxt = RUN_W'({6'd32 - {1'b0, in_amt}, in_byte[5], 1'b0});
            default: begin
              if (in_byte[5]) begin
                run_left_nxt = '0;
              end
            end
          endcase
        end
        PH_DIST: begin
          if (bad_ref) begin
            stopped_nxt = 1'b1;
            op.status   = STS_BADREF;
          end else begin
            dist_nxt = dist_calc;
          end
        end
        PH_COUNT: run_left_nxt = RUN_W'({(14'(hdr_left) + {1'b0, in_byte, 5'd0}), 2'b00});
        PH_VALUE: fill_nxt = in_byte;
        default: ;
      endcase
      if (emit) begin
        produced_nxt = produced_r + LENGTH_BITS'(1);
        run_left_nxt = run_dec;
        op.emit      = 1'b1;
        op.copy      = (phase_r == PH_COPY_RUN);
        op.copy_dist = dist_r;
        op.data      = (phase_r == PH_FILL_RUN) ? fill_r :
                       (phase_r == PH_LITERAL) ? in_byte : 8'd0;
      end
    end
    op.want = !(stopped_nxt || (produced_nxt >= out_len) ||
                (phase_nxt == PH_COPY_RUN) || (phase_nxt == PH_FILL_RUN));
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      produced_r <= '0;
      run_left_r <= '0;
      dist_r     <= '0;
      fill_r     <= '0;
      hdr_r      <= '0;
      stopped_r  <= 1'b0;
    end else if (act || (in_fire && live && phase_r == PH_DIST)) begin
      phase_r    <= phase_nxt;
      produced_r <= produced_nxt;
      run_left_r <= run_left_nxt;
      dist_r     <= dist_nxt;
      fill_r     <= fill_nxt;
      hdr_r      <= hdr_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

endmodule

FILE: rtl/lrd_fifo.sv
module lrd_fifo import lrd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output op_t  head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  op_t             slots [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CNTW-1:0] cnt_r;

  assign full      = (cnt_r == CNTW'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slots[rp_r];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      cnt_r <= cnt_r + CNTW'(push) - CNTW'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp_r] <= push_op;
    end
  end

endmodule

FILE: rtl/lrd_back.sv
module lrd_back import lrd_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  op_t        q_op,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [3:0] out_tuser
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [7:0]    hist [WINDOW_DEPTH];
  logic [AW-1:0] wptr_r, wa_r, rd_addr;
  logic [7:0]    ram_q_r;
  logic          byp_hit_r;
  logic [7:0]    byp_data_r;
  logic          r_valid_r, o_valid_r;
  op_t           r_op_r, o_op_r, o_op_nxt;
  logic [7:0]    r_data;
  logic          r_load, o_load, wr_en;

  // Stage handshakes.
  assign o_load  = r_valid_r && (!o_valid_r || out_tready);
  assign r_load  = q_valid && (!r_valid_r || o_load);
  assign q_pop   = r_load;
  assign wr_en   = o_load && r_op_r.emit;
  assign rd_addr = wptr_r - AW'(q_op.copy_dist);

  // Copy bytes take the history read, or the byte written alongside that read.
  assign r_data = r_op_r.copy ? (byp_hit_r ? byp_data_r : ram_q_r) : r_op_r.data;

  // History read for the op entering the read stage.
  always_ff @(posedge clk) begin
    if (r_load) begin
      ram_q_r    <= hist[rd_addr];
      byp_hit_r  <= wr_en && (wa_r == rd_addr);
      byp_data_r <= r_data;
      wa_r       <= wptr_r;
      r_op_r     <= q_op;
    end
  end

  // History write as an op leaves the read stage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[wa_r] <= r_data;
    end
  end

  // Output register payload: the read-stage op with its final byte.
  always_comb begin
    o_op_nxt      = r_op_r;
    o_op_nxt.data = r_data;
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_op_r <= o_op_nxt;
    end
  end

  // Stage valids and write pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      wptr_r    <= '0;
    end else begin
      if (r_load) begin
        r_valid_r <= 1'b1;
      end else if (o_load) begin
        r_valid_r <= 1'b0;
      end
      if (o_load) begin
        o_valid_r <= 1'b1;
      end else if (out_tready) begin
        o_valid_r <= 1'b0;
      end
      if (r_load && q_op.emit) begin
        wptr_r <= wptr_r + AW'(1);
      end
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_op_r.data;
  assign out_tuser  = {o_op_r.status, o_op_r.want, o_op_r.emit};

endmodule

FILE: rtl/lz_rle_byte_decompressor.sv
// LZ/RLE byte decompressor.
// The in_ channel carries one request per item: in_tuser low asks the block to
// take the compressed byte in in_tdata, in_tuser high is a tick that releases
// one byte of a pending copy or fill run. Every accepted item yields exactly
// one result item on the out_ channel with the decoded byte, a flag that says
// whether the byte is real, a hint for the kind of the next request and a
// status. cfg_ writes set the number of bytes to produce; write only while idle.
// Throughput is one item per cycle while out_tready stays high. A result passes
// through the parse queue and the history read stage, and then it sits in the
// output register. The 512-byte (WINDOW_DEPTH) history is a single-port-read
// RAM; a distance-one copy is served from a bypass of the byte written in the
// same cycle.
// Reset clears the parser, the queue and the output stage; history contents
// are left as they are and are only read after being written.
// When out_tready is low the output register holds, the queue fills and
// in_tready falls once the two queue entries are taken.
module lz_rle_byte_decompressor import lrd_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // in_byte
  input  logic                               in_tuser,   // req_type
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // out_byte
  output logic [3:0]                         out_tuser,  // status[1:0], want_byte, out_valid
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [((LENGTH_BITS+7)/8)*8-1:0]   cfg_data    // output_length
);

  logic [LENGTH_BITS-1:0] out_len_r;
  logic                   in_fire;
  logic                   q_full, q_valid, q_pop;
  op_t                    f_op, q_op;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // Output length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_len_r <= '0;
    end else if (cfg_valid) begin
      out_len_r <= cfg_data[LENGTH_BITS-1:0];
    end
  end

  lrd_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .req_type (in_tuser),
    .in_byte  (in_tdata),
    .out_len  (out_len_r),
    .op       (f_op)
  );

  lrd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_op   (f_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_op)
  );

  lrd_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/lrd_checker.sv
`include "lz_rle_byte_decompressor_defines.svh"

module lrd_checker import lrd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [3:0] out_tuser
);

  // A stalled result holds.
  `LRD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // An item without a byte carries a zero byte.
  `LRD_ASSERT_NOW(a_zero_byte, out_tvalid && !out_tuser[0], out_tdata == 8'd0)

  // A produced byte always comes with an ok status.
  `LRD_ASSERT_NOW(a_byte_ok, out_tvalid && out_tuser[0], out_tuser[3:2] == STS_OK)

  // A stopped or finished block asks for nothing more.
  `LRD_ASSERT_NOW(a_no_want, out_tvalid && (out_tuser[3:2] == STS_BADREF || out_tuser[3:2] == STS_DONE), !out_tuser[1])

endmodule

bind lz_rle_byte_decompressor lrd_checker u_checker (.*);
